@@ design/akt_pkg.sv @@
`default_nettype none
package akt_pkg;

  localparam int ALT_W    = 32;
  localparam int COV_W    = 48;
  localparam int COV_FRAC = 24;
  localparam int ACC_W    = 24;
  localparam int GAIN_W   = 16;
  localparam int TS_W     = 24;

  localparam logic [ACC_W-1:0]  ACCEL_RESET = 24'd65536;
  localparam logic [ACC_W-1:0]  MEAS_RESET  = 24'd13107;
  localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd3277;

  localparam logic [1:0] CFG_ACCEL = 2'd0;
  localparam logic [1:0] CFG_MEAS  = 2'd1;
  localparam logic [1:0] CFG_GAIN  = 2'd2;

  localparam logic [63:0] COV_MAX_U = (64'd1 << (COV_W - 1)) - 64'd1;

  typedef enum logic [2:0] {
    CLAMP_NONE,
    CLAMP_ALT,
    CLAMP_COV,
    CLAMP_WIDE,
    CLAMP_SYM
  } clamp_t;

  // One request to the shared multiply/divide unit.
  typedef struct packed {
    logic [63:0]      mag_a;
    logic [63:0]      mag_b;
    logic             neg;
    logic [5:0]       shamt;
    logic             divide;
    logic [COV_W-1:0] divisor;
    clamp_t           clamp;
  } arith_cmd_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic signed [ALT_W-1:0] alt_add(input logic signed [ALT_W-1:0] a,
                                                      input logic signed [63:0] b);
    logic signed [64:0] sum;
    logic signed [64:0] hi;
    logic signed [64:0] lo;
    hi  = (65'sd1 <<< (ALT_W - 1)) - 65'sd1;
    lo  = -(65'sd1 <<< (ALT_W - 1));
    sum = 65'(a) + 65'(b);
    if (sum > hi) begin
      return hi[ALT_W-1:0];
    end else if (sum < lo) begin
      return lo[ALT_W-1:0];
    end
    return sum[ALT_W-1:0];
  endfunction

  function automatic logic signed [COV_W-1:0] cov_add(input logic signed [COV_W-1:0] a,
                                                      input logic signed [63:0] b);
    logic signed [64:0] sum;
    logic signed [64:0] hi;
    logic signed [64:0] lo;
    hi  = (65'sd1 <<< (COV_W - 1)) - 65'sd1;
    lo  = -(65'sd1 <<< (COV_W - 1));
    sum = 65'(a) + 65'(b);
    if (sum > hi) begin
      return hi[COV_W-1:0];
    end else if (sum < lo) begin
      return lo[COV_W-1:0];
    end
    return sum[COV_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ design/altitude_kalman_tracker_top.sv @@
// Altitude tracker: exponential smoother followed by a two-state Kalman filter.
// Input channel in_*: one request per barometer sample, carrying the raw
// altitude and the time since the previous sample. Output channel out_*: one
// result per request, the filtered altitude and the vertical speed.
// The cfg_* port writes the three tuning registers; write them only while idle.
// All products and quotients go through one shared bit-serial unit: a multiply
// takes one multiplier bit per cycle, a divide one quotient bit per cycle. A
// request runs up to ten multiplies and five divides; the filter takes one
// request at a time, and that unit sets the rate.
// A new request is accepted while the previous result still waits on the
// output; the finished result of that request is held until out_tready.
// Reset (rst_n low, synchronous) restores the register defaults, clears the
// estimates, sets the position covariance to its maximum and marks the
// smoother unprimed, so the first sample loads it directly.
`default_nettype none
module altitude_kalman_tracker_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [31:0] raw_altitude, [55:32] time_step
  input  wire logic [55:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [31:0] altitude_estimate, [63:32] vertical_speed
  output logic [63:0]      out_tdata,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  import akt_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_OUT} state_t;
  typedef enum logic [4:0] {
    SP_SMOOTH, SP_T2, SP_N2, SP_N3, SP_N3H, SP_N4Q, SP_XP, SP_PP1, SP_PP2, SP_PV1,
    SP_COMMIT, SP_QX, SP_QV, SP_QVV, SP_QPV, SP_QPP, SP_APPLY
  } step_t;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;

  logic [ACC_W-1:0]  accel_r, accel_nxt;
  logic [ACC_W-1:0]  meas_r, meas_nxt;
  logic [GAIN_W-1:0] gain_r, gain_nxt;

  logic signed [ALT_W-1:0] raw_r, raw_nxt;
  logic [TS_W-1:0]         t_r, t_nxt;
  logic signed [ALT_W-1:0] x_r, x_nxt;
  logic signed [ALT_W-1:0] v_r, v_nxt;
  logic signed [ALT_W-1:0] sm_r, sm_nxt;
  logic                    primed_r, primed_nxt;
  logic signed [COV_W-1:0] pp_r, pp_nxt;
  logic signed [COV_W-1:0] pv_r, pv_nxt;
  logic signed [COV_W-1:0] vv_r, vv_nxt;
  logic signed [COV_W-1:0] ppp_r, ppp_nxt;
  logic signed [COV_W-1:0] pvp_r, pvp_nxt;
  logic signed [COV_W-1:0] s_r, s_nxt;
  logic signed [ALT_W:0]   y_r, y_nxt;
  logic [47:0]             t2_r, t2_nxt;
  logic [47:0]             n2raw_r, n2raw_nxt;
  logic [55:0]             n3raw_r, n3raw_nxt;
  logic [COV_W-1:0]        n3h_r, n3h_nxt;
  logic [COV_W-1:0]        n4q_r, n4q_nxt;
  logic signed [34:0]      qx_r, qx_nxt;
  logic signed [34:0]      qv_r, qv_nxt;
  logic signed [COV_W-1:0] qvv_r, qvv_nxt;
  logic signed [COV_W-1:0] qpv_r, qpv_nxt;
  logic signed [COV_W-1:0] qpp_r, qpp_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [63:0]             out_data_r, out_data_nxt;

  arith_cmd_t         cmd;
  logic               arith_start;
  logic               arith_done;
  logic signed [63:0] res;

  logic signed [ALT_W:0]   diff;
  logic [63:0]             n2_lim;
  logic signed [COV_W-1:0] s_calc;

  akt_arith u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (arith_start),
    .cmd    (cmd),
    .done   (arith_done),
    .result (res)
  );

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    diff        = 33'(raw_r) - 33'(sm_r);
    cmd         = '0;
    cmd.clamp   = CLAMP_NONE;
    cmd.divisor = s_r;
    unique case (step_r)
      SP_SMOOTH: begin
        cmd.mag_a = mag64(64'(diff));
        cmd.mag_b = 64'(gain_r);
        cmd.neg   = diff[ALT_W];
        cmd.shamt = 6'd16;
        cmd.clamp = CLAMP_ALT;
      end
      SP_T2: begin
        cmd.mag_a = 64'(t_r);
        cmd.mag_b = 64'(t_r);
      end
      SP_N2: begin
        cmd.mag_a = 64'(accel_r);
        cmd.mag_b = 64'(t2_r);
        cmd.shamt = 6'd24;
      end
      SP_N3: begin
        cmd.mag_a = 64'(n2raw_r);
        cmd.mag_b = 64'(t_r);
        cmd.shamt = 6'd16;
      end
      SP_N3H: begin
        cmd.mag_a = 64'(n2raw_r);
        cmd.mag_b = 64'(t_r);
        cmd.shamt = 6'd17;
        cmd.clamp = CLAMP_SYM;
      end
      SP_N4Q: begin
        cmd.mag_a = 64'(n3raw_r);
        cmd.mag_b = 64'(t_r);
        cmd.shamt = 6'd18;
        cmd.clamp = CLAMP_SYM;
      end
      SP_XP: begin
        cmd.mag_a = mag64(64'(v_r));
        cmd.mag_b = 64'(t_r);
        cmd.neg   = v_r[ALT_W-1];
        cmd.shamt = 6'd16;
        cmd.clamp = CLAMP_ALT;
      end
      SP_PP1: begin
        cmd.mag_a = mag64(64'(pv_r));
        cmd.mag_b = 64'(t_r);
        cmd.neg   = pv_r[COV_W-1];
        cmd.shamt = 6'd15;
        cmd.clamp = CLAMP_COV;
      end
      SP_PP2: begin
        cmd.mag_a = mag64(64'(vv_r));
        cmd.mag_b = 64'(t2_r);
        cmd.neg   = vv_r[COV_W-1];
        cmd.shamt = 6'd32;
        cmd.clamp = CLAMP_COV;
      end
      SP_PV1: begin
        cmd.mag_a = mag64(64'(vv_r));
        cmd.mag_b = 64'(t_r);
        cmd.neg   = vv_r[COV_W-1];
        cmd.shamt = 6'd16;
        cmd.clamp = CLAMP_COV;
      end
      SP_QX: begin
        cmd.mag_a  = mag64(64'(pp_r));
        cmd.mag_b  = mag64(64'(y_r));
        cmd.neg    = pp_r[COV_W-1] ^ y_r[ALT_W];
        cmd.divide = 1'b1;
        cmd.clamp  = CLAMP_WIDE;
      end
      SP_QV: begin
        cmd.mag_a  = mag64(64'(pv_r));
        cmd.mag_b  = mag64(64'(y_r));
        cmd.neg    = pv_r[COV_W-1] ^ y_r[ALT_W];
        cmd.divide = 1'b1;
        cmd.clamp  = CLAMP_WIDE;
      end
      SP_QVV: begin
        cmd.mag_a  = mag64(64'(pv_r));
        cmd.mag_b  = mag64(64'(pv_r));
        cmd.divide = 1'b1;
        cmd.clamp  = CLAMP_SYM;
      end
      SP_QPV: begin
        cmd.mag_a  = mag64(64'(pv_r));
        cmd.mag_b  = mag64(64'(pp_r));
        cmd.neg    = pv_r[COV_W-1] ^ pp_r[COV_W-1];
        cmd.divide = 1'b1;
        cmd.clamp  = CLAMP_SYM;
      end
      SP_QPP: begin
        cmd.mag_a  = mag64(64'(pp_r));
        cmd.mag_b  = mag64(64'(pp_r));
        cmd.divide = 1'b1;
        cmd.clamp  = CLAMP_SYM;
      end
      default: cmd.mag_a = '0;
    endcase
  end

  always_comb begin
    n2_lim = (64'(n2raw_r) > COV_MAX_U) ? COV_MAX_U : 64'(n2raw_r);
    s_calc = cov_add(ppp_r, 64'(meas_r) << (COV_FRAC - 16));
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    accel_nxt     = accel_r;
    meas_nxt      = meas_r;
    gain_nxt      = gain_r;
    raw_nxt       = raw_r;
    t_nxt         = t_r;
    x_nxt         = x_r;
    v_nxt         = v_r;
    sm_nxt        = sm_r;
    primed_nxt    = primed_r;
    pp_nxt        = pp_r;
    pv_nxt        = pv_r;
    vv_nxt        = vv_r;
    ppp_nxt       = ppp_r;
    pvp_nxt       = pvp_r;
    s_nxt         = s_r;
    y_nxt         = y_r;
    t2_nxt        = t2_r;
    n2raw_nxt     = n2raw_r;
    n3raw_nxt     = n3raw_r;
    n3h_nxt       = n3h_r;
    n4q_nxt       = n4q_r;
    qx_nxt        = qx_r;
    qv_nxt        = qv_r;
    qvv_nxt       = qvv_r;
    qpv_nxt       = qpv_r;
    qpp_nxt       = qpp_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    arith_start   = 1'b0;

    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ACCEL: accel_nxt = cfg_data;
        CFG_MEAS:  meas_nxt  = cfg_data;
        CFG_GAIN:  gain_nxt  = cfg_data[GAIN_W-1:0];
        default:   accel_nxt = accel_r;
      endcase
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          raw_nxt   = in_tdata[ALT_W-1:0];
          t_nxt     = in_tdata[ALT_W +: TS_W];
          step_nxt  = SP_SMOOTH;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (step_r == SP_SMOOTH && !primed_r) begin
          // First sample after reset loads the smoother directly.
          sm_nxt     = raw_r;
          primed_nxt = 1'b1;
          step_nxt   = SP_T2;
        end else if (step_r == SP_COMMIT) begin
          pp_nxt = ppp_r;
          pv_nxt = pvp_r;
          vv_nxt = cov_add(vv_r, signed'(n2_lim));
          s_nxt  = s_calc;
          y_nxt  = 33'(sm_r) - 33'(x_r);
          if (s_calc > 0) begin
            step_nxt = SP_QX;
          end else begin
            state_nxt = ST_OUT;
          end
        end else if (step_r == SP_APPLY) begin
          x_nxt     = alt_add(x_r, 64'(qx_r));
          v_nxt     = alt_add(v_r, 64'(qv_r));
          vv_nxt    = cov_add(vv_r, -64'(qvv_r));
          pv_nxt    = cov_add(pv_r, -64'(qpv_r));
          pp_nxt    = cov_add(pp_r, -64'(qpp_r));
          state_nxt = ST_OUT;
        end else begin
          arith_start = 1'b1;
          state_nxt   = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (arith_done) begin
          unique case (step_r)
            SP_SMOOTH: sm_nxt    = alt_add(sm_r, res);
            SP_T2:     t2_nxt    = res[47:0];
            SP_N2:     n2raw_nxt = res[47:0];
            SP_N3:     n3raw_nxt = res[55:0];
            SP_N3H:    n3h_nxt   = res[COV_W-1:0];
            SP_N4Q:    n4q_nxt   = res[COV_W-1:0];
            SP_XP:     x_nxt     = alt_add(x_r, res);
            SP_PP1:    ppp_nxt   = cov_add(pp_r, res);
            SP_PP2:    ppp_nxt   = cov_add(cov_add(ppp_r, res), 64'(n4q_r));
            SP_PV1:    pvp_nxt   = cov_add(cov_add(pv_r, res), 64'(n3h_r));
            SP_QX:     qx_nxt    = res[34:0];
            SP_QV:     qv_nxt    = res[34:0];
            SP_QVV:    qvv_nxt   = res[COV_W-1:0];
            SP_QPV:    qpv_nxt   = res[COV_W-1:0];
            SP_QPP:    qpp_nxt   = res[COV_W-1:0];
            default:   qx_nxt    = qx_r;
          endcase
          step_nxt  = step_t'(step_r + 5'd1);
          state_nxt = ST_ISSUE;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {v_r, x_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= SP_SMOOTH;
      accel_r     <= ACCEL_RESET;
      meas_r      <= MEAS_RESET;
      gain_r      <= GAIN_RESET;
      x_r         <= '0;
      v_r         <= '0;
      sm_r        <= '0;
      primed_r    <= 1'b0;
      pp_r        <= COV_MAX_U[COV_W-1:0];
      pv_r        <= '0;
      vv_r        <= COV_W'(64'(ACCEL_RESET) << (COV_FRAC - 16));
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      accel_r     <= accel_nxt;
      meas_r      <= meas_nxt;
      gain_r      <= gain_nxt;
      x_r         <= x_nxt;
      v_r         <= v_nxt;
      sm_r        <= sm_nxt;
      primed_r    <= primed_nxt;
      pp_r        <= pp_nxt;
      pv_r        <= pv_nxt;
      vv_r        <= vv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    raw_r      <= raw_nxt;
    t_r        <= t_nxt;
    ppp_r      <= ppp_nxt;
    pvp_r      <= pvp_nxt;
    s_r        <= s_nxt;
    y_r        <= y_nxt;
    t2_r       <= t2_nxt;
    n2raw_r    <= n2raw_nxt;
    n3raw_r    <= n3raw_nxt;
    n3h_r      <= n3h_nxt;
    n4q_r      <= n4q_nxt;
    qx_r       <= qx_nxt;
    qv_r       <= qv_nxt;
    qvv_r      <= qvv_nxt;
    qpv_r      <= qpv_nxt;
    qpp_r      <= qpp_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_accept_issue: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == ST_ISSUE && step_r == SP_SMOOTH)
    else $error("accepted request did not start the smoother step");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    arith_done |-> state_r == ST_WAIT)
    else $error("arithmetic result arrived while not waiting for it");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == ST_OUT)
    else $error("result raised outside the output state");

  a_start_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
    arith_start |=> state_r == ST_WAIT && !arith_done)
    else $error("arithmetic request did not enter the wait state");

endmodule
`default_nettype wire

@@ design/akt_arith.sv @@
`default_nettype none
module akt_arith (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire akt_pkg::arith_cmd_t cmd,
  output logic                    done,
  output logic signed [63:0]      result
);
  import akt_pkg::*;

  typedef enum logic [2:0] {A_IDLE, A_MUL, A_DIV, A_RND, A_CLAMP} astate_t;

  astate_t            state_r, state_nxt;
  arith_cmd_t         cmd_r, cmd_nxt;
  logic [127:0]       p_r, p_nxt;
  logic [COV_W:0]     rem_r, rem_nxt;
  logic [6:0]         cnt_r, cnt_nxt;
  logic               done_r, done_nxt;
  logic signed [63:0] res_r, res_nxt;

  logic [64:0]        add_sum;
  logic [COV_W+1:0]   rem_s;
  logic               ge;
  logic [127:0]       rnd;
  logic [63:0]        mag;
  logic [63:0]        lo_mag;
  logic [63:0]        hi_mag;

  always_comb begin
    add_sum = {1'b0, p_r[127:64]} + (p_r[0] ? {1'b0, cmd_r.mag_a} : 65'd0);
    rem_s   = {rem_r, p_r[127]};
    ge      = rem_s >= {2'b00, cmd_r.divisor};
    rnd     = (cmd_r.shamt == 6'd0) ? 128'd0 : (128'd1 << (cmd_r.shamt - 6'd1));
    mag     = (|p_r[127:64]) ? {64{1'b1}} : p_r[63:0];
    unique case (cmd_r.clamp)
      CLAMP_ALT: begin
        lo_mag = 64'h8000_0000;
        hi_mag = 64'h7FFF_FFFF;
      end
      CLAMP_COV: begin
        lo_mag = COV_MAX_U + 64'd1;
        hi_mag = COV_MAX_U;
      end
      CLAMP_WIDE: begin
        lo_mag = 64'd1 << 33;
        hi_mag = 64'd1 << 33;
      end
      CLAMP_SYM: begin
        lo_mag = COV_MAX_U;
        hi_mag = COV_MAX_U;
      end
      default: begin
        lo_mag = {64{1'b1}};
        hi_mag = {64{1'b1}};
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    p_nxt     = p_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    res_nxt   = res_r;
    unique case (state_r)
      A_IDLE: begin
        if (start) begin
          cmd_nxt   = cmd;
          p_nxt     = {64'd0, cmd.mag_b};
          cnt_nxt   = 7'd63;
          state_nxt = A_MUL;
        end
      end
      // One multiplier bit per cycle, product shifting right.
      A_MUL: begin
        p_nxt   = {add_sum, p_r[63:1]};
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd0) begin
          rem_nxt   = '0;
          cnt_nxt   = 7'd127;
          state_nxt = cmd_r.divide ? A_DIV : A_RND;
        end
      end
      // Restoring division, one quotient bit per cycle.
      A_DIV: begin
        rem_nxt = ge ? (COV_W+1)'(rem_s - {2'b00, cmd_r.divisor}) : rem_s[COV_W:0];
        p_nxt   = {p_r[126:0], ge};
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd0) begin
          state_nxt = A_RND;
        end
      end
      A_RND: begin
        p_nxt     = (p_r + rnd) >> cmd_r.shamt;
        state_nxt = A_CLAMP;
      end
      A_CLAMP: begin
        if (cmd_r.neg) begin
          res_nxt = (mag >= lo_mag) ? -signed'(lo_mag) : -signed'(mag);
        end else begin
          res_nxt = (mag > hi_mag) ? signed'(hi_mag) : signed'(mag);
        end
        done_nxt  = 1'b1;
        state_nxt = A_IDLE;
      end
      default: state_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    cmd_r <= cmd_nxt;
    p_r   <= p_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule
`default_nettype wire

@@ verif/tb_altitude_kalman_tracker_top.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_altitude_kalman_tracker_top;
  import akt_pkg::*;

  typedef logic [63:0] u64;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam longint COVMAX = (longint'(1) <<< (COV_W - 1)) - 1;
  localparam longint COVMIN = -COVMAX - 1;
  localparam longint ALTMAX = 64'sh7FFFFFFF;
  localparam longint ALTMIN = -64'sh80000000;
  localparam int SETTLE_CYCLES = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [55:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = CFG_ACCEL;
  logic [23:0] cfg_data = '0;

  altitude_kalman_tracker_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state, a copy of the block's registers and filter state.
  longint accel_var, meas_var, smooth_gain;
  longint alt_est, spd_est, p_pos, p_cross, p_spd, smoothed;
  bit primed;

  typedef struct {
    logic [31:0] alt;
    logic [31:0] spd;
  } estimate_t;
  estimate_t expected_estimates[$];

  int error_count = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  function automatic u64 magn(longint a);
    return a < 0 ? u64'(-a) : u64'(a);
  endfunction

  function automatic u64 mul_round(u64 a, u64 b, int s);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b} + (128'd1 << (s - 1))) >> s;
    if (p[127:64] != 0) return '1;
    return p[63:0];
  endfunction

  function automatic longint clamp_mag(bit neg, u64 mag, longint lo, longint hi);
    u64 lim;
    if (neg) begin
      lim = u64'(-(lo + 1)) + 1;
      if (mag >= lim) return lo;
      return -longint'(mag);
    end
    if (mag > u64'(hi)) return hi;
    return longint'(mag);
  endfunction

  function automatic longint smul(longint a, u64 b, int s, longint lo, longint hi);
    return clamp_mag(a < 0, mul_round(magn(a), b, s), lo, hi);
  endfunction

  // a*b/d truncated toward zero, quotient limited before the magnitude clamp.
  function automatic longint muldiv(longint a, longint b, u64 d, longint lo, longint hi);
    logic [127:0] q;
    u64 ql;
    q = ({64'd0, magn(a)} * {64'd0, magn(b)}) / {64'd0, d};
    ql = (q[127:64] != 0) ? '1 : q[63:0];
    return clamp_mag((a < 0) != (b < 0), ql, lo, hi);
  endfunction

  function automatic longint sat_sum(longint a, longint b, longint lo, longint hi);
    logic signed [65:0] s;
    s = 66'(a) + 66'(b);
    if (s > 66'(hi)) return hi;
    if (s < 66'(lo)) return lo;
    return longint'(s);
  endfunction

  function automatic longint cov_sum(longint a, longint b);
    return sat_sum(a, b, COVMIN, COVMAX);
  endfunction

  function automatic longint noise_lim(u64 v);
    return v > u64'(COVMAX) ? COVMAX : longint'(v);
  endfunction

  function automatic void reset_tracker();
    accel_var = ACCEL_RESET;
    meas_var = MEAS_RESET;
    smooth_gain = GAIN_RESET;
    alt_est = 0;
    spd_est = 0;
    p_pos = COVMAX;
    p_cross = 0;
    p_spd = longint'(ACCEL_RESET) <<< (COV_FRAC - 16);
    smoothed = 0;
    primed = 0;
  endfunction

  function automatic estimate_t track_sample(logic [31:0] raw_bits, logic [23:0] ts);
    longint raw, pp, pv, vv, s, y, n2, n3h, n4q, wide;
    u64 t, t2, n2raw, n3raw;
    estimate_t e;
    raw = longint'(signed'(raw_bits));
    t = u64'(ts);
    if (primed) begin
      smoothed = sat_sum(smoothed,
                         smul(raw - smoothed, u64'(smooth_gain), 16, ALTMIN, ALTMAX),
                         ALTMIN, ALTMAX);
    end else begin
      smoothed = raw;
      primed = 1;
    end
    t2 = t * t;
    n2raw = mul_round(u64'(accel_var), t2, 24);
    n3raw = mul_round(n2raw, t, 16);
    n2 = noise_lim(n2raw);
    n3h = noise_lim(mul_round(n2raw, t, 17));
    n4q = noise_lim(mul_round(n3raw, t, 18));
    alt_est = sat_sum(alt_est, smul(spd_est, t, 16, ALTMIN, ALTMAX), ALTMIN, ALTMAX);
    pp = cov_sum(p_pos, smul(p_cross, t, 15, COVMIN, COVMAX));
    pp = cov_sum(pp, smul(p_spd, t2, 32, COVMIN, COVMAX));
    pp = cov_sum(pp, n4q);
    pv = cov_sum(p_cross, smul(p_spd, t, 16, COVMIN, COVMAX));
    pv = cov_sum(pv, n3h);
    vv = cov_sum(p_spd, n2);
    p_pos = pp;
    p_cross = pv;
    p_spd = vv;
    s = cov_sum(pp, meas_var <<< (COV_FRAC - 16));
    // A non-positive innovation variance skips the update entirely.
    if (s > 0) begin
      wide = longint'(1) <<< 33;
      y = smoothed - alt_est;
      alt_est = sat_sum(alt_est, muldiv(pp, y, u64'(s), -wide, wide), ALTMIN, ALTMAX);
      spd_est = sat_sum(spd_est, muldiv(pv, y, u64'(s), -wide, wide), ALTMIN, ALTMAX);
      p_spd = cov_sum(vv, -muldiv(pv, pv, u64'(s), -COVMAX, COVMAX));
      p_cross = cov_sum(pv, -muldiv(pv, pp, u64'(s), -COVMAX, COVMAX));
      p_pos = cov_sum(pp, -muldiv(pp, pp, u64'(s), -COVMAX, COVMAX));
    end
    e.alt = alt_est[31:0];
    e.spd = spd_est[31:0];
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s at %0t: got %h expected %h", what, $time, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    estimate_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_estimates.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[31:0], 'x);
      end else begin
        e = expected_estimates.pop_front();
        results_checked++;
        if (out_tdata[31:0] !== e.alt) report_mismatch("altitude", out_tdata[31:0], e.alt);
        if (out_tdata[63:32] !== e.spd) report_mismatch("speed", out_tdata[63:32], e.spd);
      end
    end
  end

  task automatic wait_idle();
    while (expected_estimates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_wr_en high; the caller lowers it after the last write.
  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_ACCEL: accel_var = val;
      CFG_MEAS: meas_var = val;
      CFG_GAIN: smooth_gain = val[15:0];
      default: ;
    endcase
  endtask

  task automatic send_sample(logic [31:0] raw, logic [23:0] ts, bit chk,
                             logic [31:0] ealt, logic [31:0] espd);
    estimate_t e;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {ts, raw};
    do @(posedge clk); while (!in_tready);
    e = track_sample(raw, ts);
    // Rows with a value read straight off the filter equations check it too.
    if (chk && e.alt !== ealt) report_mismatch("directed altitude", e.alt, ealt);
    if (chk && e.spd !== espd) report_mismatch("directed speed", e.spd, espd);
    expected_estimates.push_back(e);
    requests_sent++;
  endtask

  task automatic end_burst();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  typedef struct {
    bit is_cfg;
    logic [1:0] idx;
    logic [23:0] val;
    logic [31:0] raw;
    logic [23:0] ts;
    bit chk;
    logic [31:0] ealt;
    logic [31:0] espd;
  } stim_row_t;
  stim_row_t directed[$];

  task automatic add_item(logic [31:0] raw, logic [23:0] ts);
    directed.push_back('{0, CFG_ACCEL, 24'd0, raw, ts, 0, 32'd0, 32'd0});
  endtask

  task automatic add_cfg(logic [1:0] idx, logic [23:0] val);
    directed.push_back('{1, idx, val, 32'd0, 24'd0, 0, 32'd0, 32'd0});
  endtask

  initial begin
    logic [31:0] walk;
    logic [31:0] raw;
    logic [23:0] ts;
    bit in_cfg;
    int r;

    // First sample loads the smoother and, with maximal position covariance,
    // the altitude estimate itself; speed stays zero.
    directed.push_back('{0, CFG_ACCEL, 24'd0, 32'h003E8000, 24'd0, 1,
                         32'h003E8000, 32'd0});
    add_item(32'h003E9000, 24'h001999);
    add_item(32'h7FFFFFFF, 24'h010000);
    add_item(32'h80000000, 24'h010000);
    add_item(32'h00000000, 24'hFFFFFF);
    add_item(32'h7FFFFFFF, 24'hFFFFFF);
    add_item(32'h12345678, 24'h000000);
    // Zero measurement variance collapses the position covariance, so a
    // following zero time step leaves a non-positive innovation variance.
    add_cfg(CFG_MEAS, 24'd0);
    add_cfg(CFG_ACCEL, 24'hFFFFFF);
    add_item(32'h00100000, 24'h004000);
    add_item(32'h00200000, 24'h000000);
    add_item(32'hFFF00000, 24'h000000);
    add_cfg(CFG_UNUSED, 24'hFFFFFF);
    add_cfg(CFG_GAIN, 24'h00FFFF);
    add_cfg(CFG_ACCEL, 24'd0);
    add_cfg(CFG_MEAS, 24'hFFFFFF);
    add_item(32'h00300000, 24'h008000);
    add_item(32'h80000000, 24'h000001);
    add_cfg(CFG_GAIN, 24'd0);
    add_item(32'h7FFFFFFF, 24'h020000);
    add_item(32'h00000001, 24'h000100);

    reset_tracker();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_cfg = 0;
    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        if (!in_cfg) begin
          end_burst();
          wait_idle();
        end
        in_cfg = 1;
        write_reg(directed[i].idx, directed[i].val);
      end else begin
        if (in_cfg) cfg_wr_en <= 1'b0;
        in_cfg = 0;
        send_sample(directed[i].raw, directed[i].ts, directed[i].chk,
                    directed[i].ealt, directed[i].espd);
      end
    end

    walk = 32'h00100000;
    for (int phase = 0; phase < 4; phase++) begin
      end_burst();
      wait_idle();
      case (phase)
        0: begin
          write_reg(CFG_ACCEL, ACCEL_RESET);
          write_reg(CFG_MEAS, MEAS_RESET);
          write_reg(CFG_GAIN, GAIN_RESET);
          idle_pct = 0; stall_pct = 0;
        end
        1: begin
          write_reg(CFG_ACCEL, 24'hFFFFFF);
          write_reg(CFG_MEAS, 24'd0);
          write_reg(CFG_GAIN, 24'h00FFFF);
          idle_pct = 67; stall_pct = 0;
        end
        2: begin
          write_reg(CFG_ACCEL, 24'd0);
          write_reg(CFG_MEAS, 24'hFFFFFF);
          write_reg(CFG_GAIN, 24'd0);
          idle_pct = 0; stall_pct = 67;
        end
        default: begin
          write_reg(CFG_ACCEL, 24'($urandom_range(24'h040000)));
          write_reg(CFG_MEAS, 24'($urandom_range(24'h010000)));
          write_reg(CFG_UNUSED, 24'($urandom));
          write_reg(CFG_GAIN, 24'($urandom_range(16'hFFFF)));
          idle_pct = 21; stall_pct = 21;
        end
      endcase
      cfg_wr_en <= 1'b0;
      for (int n = 0; n < 95; n++) begin
        r = $urandom_range(99);
        // Mostly a slow climb or sink with realistic steps; some wild samples.
        if (r < 10) raw = $urandom;
        else begin
          walk = walk + 32'($signed($urandom_range(16'hFFFF)) - 32'sd32768) * 4;
          raw = walk;
        end
        r = $urandom_range(99);
        if (r < 5) ts = 24'd0;
        else if (r < 15) ts = 24'($urandom);
        else ts = 24'($urandom_range(24'h006000));
        send_sample(raw, ts, 0, 32'd0, 32'd0);
      end
    end
    end_burst();

    while (expected_estimates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d samples over four tuning settings and idle mixes; %0d estimates checked.",
             requests_sent, results_checked);
    if (error_count == 0) begin
      $display("altitude_kalman_tracker_top regression: pass");
    end else begin
      $display("altitude_kalman_tracker_top regression: fail");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timed out with %0d estimates outstanding.", expected_estimates.size());
    $display("altitude_kalman_tracker_top regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
